// File: hw/rtl/rnfb_pkg.sv
// shared types and constants of the rotated nibble framebuffer pixel engine
package rnfb_pkg;

   // operation codes carried in the request tuser
   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_INVERT = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   // register word index of the csr port
   localparam logic REG_DISPLAY_READY = 1'b0;

   localparam logic [7:0] LOW_NIB_MASK  = 8'h0F;
   localparam logic [7:0] HIGH_NIB_MASK = 8'hF0;

   // control of the single framebuffer port
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } rnfb_mem_ctl_type;

endpackage

// File: hw/rtl/rotated_nibble_framebuffer_pixel_ops.sv
// top level of the rotated 4bpp framebuffer pixel engine
//
// usage
//  - req channel: one transfer per logical portrait pixel; tuser carries the
//    operation (write mapped gray, invert nibble, read nibble), tdata the
//    coordinates and gray level, tlast marks the last pixel of a rectangle
//  - rsp channel: exactly one transfer per request, in order; tuser is the
//    skipped flag, tdata the resulting nibble, tlast echoes the request tlast
//  - csr port: apb-style, one register display_ready at address 0
//  - each pixel is a read-modify-write: the accept cycle computes the rotated
//    byte address and reads the single memory port, then ST_MODIFY modifies
//    the nibble, writes the byte back and loads the response register once
//    the response slot is free; a new pixel is taken only after the
//    write-back of the last one, set by the read-modify-write on the one port
//  - reset clears display_ready and then sweeps the framebuffer to zero, one
//    byte per cycle over PANEL_HEIGHT*((PANEL_WIDTH+1)/2) bytes (259200 at the
//    default size); req_tready stays low during the sweep, csr writes still go
//  - a stalled receiver holds the response register; one more request is
//    taken meanwhile and waits before its write-back until the slot frees
module rotated_nibble_framebuffer_pixel_ops import rnfb_pkg::*; #(
   parameter int PANEL_WIDTH  = 960,
   parameter int PANEL_HEIGHT = 540
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // x_pos[9:0], y_pos[19:10], gray[27:20], zero pad
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   input  logic        req_tlast,   // last_pixel
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // pixel_nibble[3:0], zero pad
   output logic [0:0]  rsp_tuser,   // skipped
   output logic        rsp_tlast,   // op_done
   // csr port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int ROW_BYTES   = (PANEL_WIDTH + 1) / 2;
   localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
   localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_MODIFY = 2'd2;

   // request fields
   logic [9:0] x_pos;
   logic [9:0] y_pos;
   logic [7:0] gray;
   assign x_pos = req_tdata[9:0];
   assign y_pos = req_tdata[19:10];
   assign gray  = req_tdata[27:20];

   // csr
   logic ready_ff, ready_in;
   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      ready_in = ready_ff;
      if (csr_wr && csr_paddr[2] == REG_DISPLAY_READY) begin
         ready_in = csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_DISPLAY_READY) ? {31'd0, ready_ff} : 32'd0;

   // control state
   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;

   // per-pixel context captured at accept
   logic [1:0]        cmd_ff, cmd_in;
   logic              skip_ff, skip_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              high_ff, high_in;
   logic [3:0]        gray_hi_ff, gray_hi_in;
   logic              last_ff, last_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_skip_ff, rsp_skip_in;
   logic [3:0] rsp_nib_ff, rsp_nib_in;
   logic       rsp_last_ff, rsp_last_in;

   // memory port
   rnfb_mem_ctl_type  mem_ctl;
   logic [ADDR_W-1:0] mem_addr;
   logic [7:0]        mem_wdata;
   logic [7:0]        mem_rdata;

   // rotation: column = y, row = height-1-x
   logic              clip_now;
   logic [ADDR_W-1:0] row_now;
   logic [ADDR_W-1:0] addr_now;
   logic              accept;
   logic              rsp_free;

   assign clip_now = (32'(x_pos) >= 32'(PANEL_HEIGHT)) || (32'(y_pos) >= 32'(PANEL_WIDTH));
   assign row_now  = ADDR_W'(PANEL_HEIGHT - 1) - ADDR_W'(x_pos);
   assign addr_now = ADDR_W'(row_now * ADDR_W'(ROW_BYTES)) + ADDR_W'(y_pos[9:1]);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // nibble modify
   logic [3:0] old_nib;
   logic [3:0] new_nib;
   logic       do_write;
   logic [7:0] new_byte;

   assign old_nib = high_ff ? mem_rdata[7:4] : mem_rdata[3:0];

   always_comb begin
      case (cmd_ff)
         CMD_WRITE:  new_nib = ~gray_hi_ff;
         CMD_INVERT: new_nib = ~old_nib;
         default:    new_nib = old_nib;
      endcase
   end

   assign do_write = !skip_ff && (cmd_ff == CMD_WRITE || cmd_ff == CMD_INVERT);
   assign new_byte = high_ff ? ((mem_rdata & LOW_NIB_MASK) | {new_nib, 4'd0})
                             : ((mem_rdata & HIGH_NIB_MASK) | {4'd0, new_nib});

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      cmd_in       = cmd_ff;
      skip_in      = skip_ff;
      addr_in      = addr_ff;
      high_in      = high_ff;
      gray_hi_in   = gray_hi_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_skip_in  = rsp_skip_ff;
      rsp_nib_in   = rsp_nib_ff;
      rsp_last_in  = rsp_last_ff;
      mem_ctl      = '0;
      mem_addr     = addr_ff;
      mem_wdata    = new_byte;

      unique case (state_ff)
         ST_CLEAR: begin
            // zero sweep after reset
            mem_ctl.wr_en = 1'b1;
            mem_addr      = clr_cnt_ff;
            mem_wdata     = 8'd0;
            clr_cnt_in    = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in        = req_tuser;
               skip_in       = clip_now | ~ready_ff;
               addr_in       = addr_now;
               high_in       = y_pos[0];
               gray_hi_in    = gray[7:4];
               last_in       = req_tlast;
               mem_ctl.rd_en = ~(clip_now | ~ready_ff);
               mem_addr      = addr_now;
               state_in      = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            // write back only once the response slot can take the result
            if (rsp_free) begin
               mem_ctl.wr_en = do_write;
               rsp_valid_in  = 1'b1;
               rsp_skip_in   = skip_ff;
               rsp_nib_in    = skip_ff ? 4'd0 : new_nib;
               rsp_last_in   = last_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      skip_ff     <= skip_in;
      addr_ff     <= addr_in;
      high_ff     <= high_in;
      gray_hi_ff  <= gray_hi_in;
      last_ff     <= last_in;
      rsp_skip_ff <= rsp_skip_in;
      rsp_nib_ff  <= rsp_nib_in;
      rsp_last_ff <= rsp_last_in;
   end

   rnfb_store #(
      .DEPTH  (STORE_BYTES),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_nib_ff};
   assign rsp_tuser  = rsp_skip_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: hw/rtl/rnfb_store.sv
// single-port framebuffer byte memory with registered read data
module rnfb_store import rnfb_pkg::*; #(
   parameter int DEPTH  = 259200,
   parameter int ADDR_W = 18
) (
   input  logic                  clock,
   input  rnfb_mem_ctl_type      ctl,
   input  logic [ADDR_W-1:0]     addr,
   input  logic [7:0]            wr_data,
   output logic [7:0]            rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: dv/tb.sv
// testbench for the rotated 4bpp framebuffer pixel engine: directed and random pixel traffic
`timescale 1ns / 1ps

module tb;
   import rnfb_pkg::*;

   // panel geometry, matches the default parameters of the dut
   localparam int PANEL_W     = 960;
   localparam int PANEL_H     = 540;
   localparam int ROW_BYTES   = (PANEL_W + 1) / 2;
   localparam int STORE_BYTES = ROW_BYTES * PANEL_H;

   // the unused operation code, handled by the block like a read
   localparam logic [1:0] CMD_SPARE = 2'd3;

   // byte address of the display_ready register
   localparam logic [2:0] DISPLAY_READY_ADDR = {REG_DISPLAY_READY, 2'b00};

   // run limit: the clearing sweep after reset plus ample room for the traffic
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [1:0] cmd;
      logic [9:0] x_pos;
      logic [9:0] y_pos;
      logic [7:0] gray;
      logic       last;
   } pixel_req_type;

   typedef struct packed {
      logic       skipped;
      logic [3:0] nibble;
      logic       op_done;
   } pixel_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // x_pos[9:0], y_pos[19:10], gray[27:20], zero pad
   logic [1:0]  req_tuser = '0;   // cmd[1:0]
   logic        req_tlast = 1'b0; // last_pixel
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // pixel_nibble[3:0], zero pad
   logic [0:0]  rsp_tuser;        // skipped
   logic        rsp_tlast;        // op_done
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rotated_nibble_framebuffer_pixel_ops dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow of the framebuffer and of display_ready, both zero after reset
   bit [7:0]   fb_shadow [STORE_BYTES];
   bit         ready_shadow = 1'b0;

   pixel_req_type pending_pixels [$];
   pixel_rsp_type expected_pixels [$];
   pixel_req_type next_pixel;
   pixel_rsp_type oldest_pixel;

   int         error_count = 0;
   int         cycle_count = 0;
   bit         idle_on = 1'b0;
   int         req_gap = 0;
   int         stall_left = 0;
   int         hold_left = 0;
   int         hold_requests = 0;
   int         hold_served = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // rotate to physical coordinates, apply the operation to the shadow store
   function automatic pixel_rsp_type predict_pixel(pixel_req_type p);
      pixel_rsp_type r;
      int unsigned row;
      int unsigned addr;
      bit [7:0]    cur;
      bit [3:0]    nib;
      bit          hi;
      r.skipped = 1'b1;
      r.nibble  = 4'd0;
      r.op_done = p.last;
      // not ready, or clipped outside the logical portrait area
      if (!ready_shadow || p.x_pos >= PANEL_H || p.y_pos >= PANEL_W) return r;
      row  = PANEL_H - 1 - p.x_pos;
      addr = row * ROW_BYTES + (p.y_pos >> 1);
      hi   = p.y_pos[0];
      cur  = fb_shadow[addr];
      nib  = hi ? cur[7:4] : cur[3:0];
      case (p.cmd)
         CMD_WRITE:  nib = 4'd15 - p.gray[7:4];
         CMD_INVERT: nib = 4'd15 - nib;
         default: ;  // read and the spare code leave the store alone
      endcase
      if (p.cmd == CMD_WRITE || p.cmd == CMD_INVERT) begin
         if (hi) cur[7:4] = nib;
         else    cur[3:0] = nib;
         fb_shadow[addr] = cur;
      end
      r.skipped = 1'b0;
      r.nibble  = nib;
      return r;
   endfunction

   // request driver: one transfer per queued pixel, random gaps between them while idling is on
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap != 0) begin
            req_tvalid <= 1'b0;
            req_gap    <= req_gap - 1;
         end else if (pending_pixels.size() != 0) begin
            next_pixel = pending_pixels.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {4'b0, next_pixel.gray, next_pixel.y_pos, next_pixel.x_pos};
            req_tuser  <= next_pixel.cmd;
            req_tlast  <= next_pixel.last;
            req_gap    <= idle_on ? pick_gap() : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response receiver: random stalls while idling is on, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= (idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
   end

   // prediction on every request transfer, check on every response transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_pixels.push_back(predict_pixel(
               {req_tuser, req_tdata[9:0], req_tdata[19:10], req_tdata[27:20], req_tlast}));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               error_count++;
               $display("%t: response with nothing expected: skipped %b nibble %h op_done %b",
                        $time, rsp_tuser[0], rsp_tdata, rsp_tlast);
            end else begin
               oldest_pixel = expected_pixels.pop_front();
               if (rsp_tuser[0] !== oldest_pixel.skipped) begin
                  error_count++;
                  $display("%t: skipped expected %b actual %b",
                           $time, oldest_pixel.skipped, rsp_tuser[0]);
               end
               if (rsp_tdata !== {4'b0, oldest_pixel.nibble}) begin
                  error_count++;
                  $display("%t: pixel_nibble expected %h actual %h",
                           $time, {4'b0, oldest_pixel.nibble}, rsp_tdata);
               end
               if (rsp_tlast !== oldest_pixel.op_done) begin
                  error_count++;
                  $display("%t: op_done expected %b actual %b",
                           $time, oldest_pixel.op_done, rsp_tlast);
               end
            end
         end
      end
   end

   // run limit, covers the framebuffer clearing sweep after reset
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rotated_nibble_framebuffer_pixel_ops test failed");
         $finish;
      end
   end

   task automatic add_pixel(input logic [1:0] cmd, input int x, input int y,
                            input int gray, input bit last);
      pixel_req_type p;
      p.cmd   = cmd;
      p.x_pos = x[9:0];
      p.y_pos = y[9:0];
      p.gray  = gray[7:0];
      p.last  = last;
      pending_pixels.push_back(p);
   endtask

   // apb write: setup cycle, then access cycle; the register takes it at the end of the access cycle
   task automatic write_display_ready(input bit value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= DISPLAY_READY_ADDR;
      csr_pwdata  <= {31'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      ready_shadow = value;
   endtask

   // block until every queued pixel went out and every response came back
   task automatic wait_drained();
      @(negedge clock);
      while (pending_pixels.size() != 0 || req_tvalid || expected_pixels.size() != 0)
         @(negedge clock);
   endtask

   // random traffic: rectangle walks over a small hot area so pixels get revisited,
   // single pokes into the same area, and noise over the whole coordinate range
   task automatic add_random_traffic(input int count);
      int added;
      int hx;
      int hy;
      int x0;
      int y0;
      int w;
      int h;
      int r;
      logic [1:0] cmd;
      added = 0;
      case ($urandom_range(0, 3))
         0: begin hx = 0;   hy = 0;   end
         1: begin hx = 530; hy = 950; end  // rectangles run off both edges
         default: begin
            hx = $urandom_range(0, 530);
            hy = $urandom_range(0, 950);
         end
      endcase
      while (added < count) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            x0  = hx + $urandom_range(0, 7);
            y0  = hy + $urandom_range(0, 7);
            w   = $urandom_range(1, 6);
            h   = $urandom_range(1, 6);
            cmd = 2'($urandom_range(0, 3));
            for (int i = 0; i < h; i++)
               for (int j = 0; j < w; j++)
                  add_pixel(cmd, x0 + i, y0 + j, $urandom_range(0, 255),
                            i == h - 1 && j == w - 1);
            added += w * h;
         end else if (r < 85) begin
            add_pixel(2'($urandom_range(0, 3)), hx + $urandom_range(0, 9),
                      hy + $urandom_range(0, 9), $urandom_range(0, 255),
                      1'($urandom_range(0, 1)));
            added++;
         end else begin
            add_pixel(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                      $urandom_range(0, 1023), $urandom_range(0, 255),
                      1'($urandom_range(0, 1)));
            added++;
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // display not ready: everything comes back skipped, store untouched
      write_display_ready(1'b0);
      add_pixel(CMD_WRITE, 0, 0, 255, 1'b1);
      add_pixel(CMD_INVERT, 539, 959, 0, 1'b0);
      add_pixel(CMD_READ, 100, 200, 0, 1'b1);
      wait_drained();

      write_display_ready(1'b1);
      // both nibbles of one byte, corners, gray extremes, every operation
      add_pixel(CMD_WRITE, 0, 0, 0, 1'b0);
      add_pixel(CMD_WRITE, 0, 1, 255, 1'b0);
      add_pixel(CMD_READ, 0, 0, 0, 1'b0);
      add_pixel(CMD_INVERT, 0, 1, 0, 1'b0);
      add_pixel(CMD_SPARE, 0, 1, 255, 1'b1);
      add_pixel(CMD_WRITE, 539, 959, 8'h10, 1'b1);
      add_pixel(CMD_INVERT, 539, 959, 0, 1'b0);
      add_pixel(CMD_WRITE, 539, 0, 8'h80, 1'b0);
      add_pixel(CMD_WRITE, 0, 959, 8'h7F, 1'b0);
      add_pixel(CMD_READ, 0, 959, 0, 1'b0);
      add_pixel(CMD_INVERT, 538, 958, 0, 1'b0);
      add_pixel(CMD_READ, 538, 958, 0, 1'b1);
      // clipped: just past either logical edge, and the top of the field range
      add_pixel(CMD_WRITE, 540, 0, 0, 1'b0);
      add_pixel(CMD_WRITE, 0, 960, 0, 1'b1);
      add_pixel(CMD_INVERT, 1023, 1023, 255, 1'b1);
      add_pixel(CMD_READ, 1023, 0, 0, 1'b0);
      add_pixel(CMD_READ, 539, 959, 0, 1'b1);
      wait_drained();

      // random traffic with idling on both sides
      idle_on = 1'b1;
      add_random_traffic(250);
      wait_drained();
      add_random_traffic(250);
      wait_drained();

      // not ready again: all skipped, and later reads show nothing changed
      write_display_ready(1'b0);
      add_random_traffic(80);
      wait_drained();

      // back-to-back stretch while the receiver holds off, so the input stalls
      write_display_ready(1'b1);
      idle_on = 1'b0;
      hold_requests = hold_requests + 1;
      add_random_traffic(300);
      wait_drained();

      idle_on = 1'b1;
      add_random_traffic(200);
      wait_drained();
      add_random_traffic(200);
      wait_drained();

      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("rotated_nibble_framebuffer_pixel_ops test passed");
      else
         $display("rotated_nibble_framebuffer_pixel_ops test failed");
      $finish;
   end

endmodule
